>>> rtl/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define AST_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet during reset
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, also checked across reset
`define AST_NEXT_ALL(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/alle_pkg.sv
`timescale 1ns / 1ps
package alle_pkg;
   localparam int CAPACITY_DEF   = 16;
   localparam int VALUE_BITS_DEF = 32;

   typedef enum logic [2:0] {
      FN_GET    = 3'd0,
      FN_SET    = 3'd1,
      FN_APPEND = 3'd2,
      FN_INSERT = 3'd3,
      FN_REMOVE = 3'd4,
      FN_SEARCH = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_POS_BAD   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DONE = 3'b100
   } state_type;
endpackage

>>> rtl/alle_cell.sv
`timescale 1ns / 1ps
module alle_cell #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic [VALUE_BITS-1:0] data_in,
   output logic [VALUE_BITS-1:0] data_out
);
   logic [VALUE_BITS-1:0] value_ff;

   // one list element; moves one place toward the head on each shift
   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= data_in;
      end
   end

   assign data_out = value_ff;
endmodule

>>> rtl/array_linked_list_engine.sv
`timescale 1ns / 1ps
// per beat: accept in idle, one full ring rotation through all cells, then load the response
//   register, which waits while an older response is still unread
// one request at a time: no new request is taken until the engine is back in idle
// reset: synchronous active high; list empties, no request or response pending
// cell contents are not cleared, empty cells are never read as data
module array_linked_list_engine #(
   parameter int CAPACITY   = alle_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = alle_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // position[3:0], value_in[35:4], zero pad
   input  logic [2:0]  req_tuser,  // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // value_out[31:0], found_position[35:32],
                                   // status[37:36], list_length[42:38], zero pad
);
   import alle_pkg::*;

   localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW   = $clog2(CAPACITY + 1);
   localparam int CMPW = ((LW > 4) ? LW : 4) + 1;

   // ring of cells, cell 0 is the current list position of the walk
   logic [VALUE_BITS-1:0] cell_q [CAPACITY];
   logic [VALUE_BITS-1:0] ring_in;
   logic                  shift_en;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [VALUE_BITS-1:0] cin;
         if (gi == CAPACITY - 1) begin : g_tail
            assign cin = ring_in;
         end else begin : g_mid
            assign cin = cell_q[gi+1];
         end
         alle_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .data_in  (cin),
            .data_out (cell_q[gi])
         );
      end
   endgenerate

   // control and request registers
   state_type             state_ff, state_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [LW-1:0]         len_ff, len_in;
   func_type              func_ff, func_in;
   logic [3:0]            pos_ff, pos_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   status_type            status_ff, status_in;
   logic [VALUE_BITS-1:0] buf_ff, buf_in;     // displaced element during insert
   logic [VALUE_BITS-1:0] vout_ff, vout_in;
   logic [3:0]            fpos_ff, fpos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [47:0]           rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [63:0]           val_wide;
   logic [63:0]           vout_wide;
   logic [CMPW-1:0]       k_c, pos_c, len_c, req_pos_c;
   logic                  req_pos_ok, req_full, last_step;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign val_wide   = {28'b0, req_tdata[39:4]} & 64'h0000_0000_FFFF_FFFF;
   assign k_c        = CMPW'(step_ff);
   assign pos_c      = CMPW'(pos_ff);
   assign len_c      = CMPW'(len_ff);
   assign req_pos_c  = CMPW'(req_tdata[3:0]);
   assign req_pos_ok = req_pos_c < len_c;
   assign req_full   = len_c >= CMPW'(CAPACITY);
   assign last_step  = (step_ff == SW'(CAPACITY - 1));
   assign shift_en   = (state_ff == S_RUN);
   assign vout_wide  = 64'(vout_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      len_in       = len_ff;
      func_in      = func_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      buf_in       = buf_ff;
      vout_in      = vout_ff;
      fpos_in      = fpos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ring_in      = cell_q[0];   // by default the element goes round unchanged

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = func_type'(req_tuser[2:0]);
               pos_in  = req_tdata[3:0];
               val_in  = val_wide[VALUE_BITS-1:0];
               step_in = '0;
               vout_in = '0;
               fpos_in = '0;
               // range and room checks come before any walk
               case (func_type'(req_tuser[2:0]))
                  FN_GET, FN_SET, FN_REMOVE:
                     status_in = req_pos_ok ? ST_OK : ST_POS_BAD;
                  FN_APPEND:
                     status_in = req_full ? ST_FULL : ST_OK;
                  FN_INSERT:
                     status_in = !req_pos_ok ? ST_POS_BAD : (req_full ? ST_FULL : ST_OK);
                  FN_SEARCH:
                     status_in = ST_NOT_FOUND;
                  default:
                     status_in = ST_OK;
               endcase
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            case (func_ff)
               FN_GET: begin
                  if (status_ff == ST_OK && k_c == pos_c) begin
                     vout_in = cell_q[0];
                  end
               end
               FN_SET: begin
                  if (status_ff == ST_OK && k_c == pos_c) begin
                     vout_in = cell_q[0];
                     ring_in = val_ff;
                  end
               end
               FN_APPEND: begin
                  // the first empty cell takes the new value
                  if (status_ff == ST_OK && k_c == len_c) begin
                     ring_in = val_ff;
                  end
               end
               FN_INSERT: begin
                  // from the position on, everything comes out one step late
                  if (status_ff == ST_OK && k_c >= pos_c) begin
                     ring_in = (k_c == pos_c) ? val_ff : buf_ff;
                     buf_in  = cell_q[0];
                  end
               end
               FN_REMOVE: begin
                  // from the position on, the next cell closes the gap
                  if (status_ff == ST_OK && k_c >= pos_c) begin
                     ring_in = last_step ? '0 : cell_q[1];
                     if (k_c == pos_c) begin
                        vout_in = cell_q[0];
                     end
                  end
               end
               FN_SEARCH: begin
                  // first match only: status leaves not-found once
                  if (status_ff == ST_NOT_FOUND && k_c < len_c && cell_q[0] == val_ff) begin
                     status_in = ST_OK;
                     fpos_in   = 4'(step_ff);
                  end
               end
               default: begin
               end
            endcase
            step_in = step_ff + 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait here only while an older response is still unread
            if (!rsp_valid_ff || rsp_tready) begin
               if (status_ff == ST_OK) begin
                  if (func_ff == FN_APPEND || func_ff == FN_INSERT) begin
                     len_in = len_ff + 1'b1;
                  end else if (func_ff == FN_REMOVE) begin
                     len_in = len_ff - 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, 5'(len_in), status_ff, fpos_ff, vout_wide[31:0]};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      buf_ff      <= buf_in;
      vout_ff     <= vout_in;
      fpos_ff     <= fpos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

>>> rtl/alle_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module alle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   import alle_pkg::*;

   logic       req_beat;
   logic [1:0] rsp_status;
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_status = rsp_tdata[37:36];

   `AST_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `AST_NEXT(a_busy_after_req, clock, reset, req_beat, !req_tready)
   `AST_NEXT_ALL(a_reset_clears_rsp, clock, reset, !rsp_tvalid && req_tready)
   `AST_IMPL(a_full_len, clock, reset, rsp_tvalid && rsp_status == ST_FULL, rsp_tdata[42:38] == 5'(CAPACITY_DEF))
endmodule

bind array_linked_list_engine alle_checker u_alle_checker (.*);

>>> bench/tb_array_linked_list_engine.sv
`timescale 1ns / 1ps
module tb_array_linked_list_engine;
   import alle_pkg::*;

   localparam int SLOTS     = 16;
   localparam int NIL       = SLOTS;
   localparam int LATENCY   = SLOTS + 2;
   localparam int IDLE_STOP = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position[3:0], value_in[35:4], zero pad
   logic [2:0]  req_tuser = '0;   // func[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // value_out, found_position, status, list_length, pad

   // packed from the top bit down, so value_out lands in the low bits
   typedef struct packed {
      logic [4:0]  length;
      logic [1:0]  status;
      logic [3:0]  found_pos;
      logic [31:0] value_out;
   } answer_type;

   // shadow copy of the list engine
   int unsigned head, free_head, count;
   int unsigned links [SLOTS];
   logic [31:0] vals  [SLOTS];

   answer_type answers_due [$];
   int         fail_count = 0;
   int         idle_cycles = 0;

   array_linked_list_engine dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // gap length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned slot_of(int unsigned pos);
      int unsigned s;
      s = head;
      for (int i = 0; i < pos && s < NIL; i++) s = links[s];
      return s;
   endfunction

   function automatic void shadow_reset();
      for (int i = 0; i < SLOTS; i++) links[i] = i + 1;
      head = NIL;
      free_head = 0;
      count = 0;
   endfunction

   // apply one request to the shadow list and produce its answer
   function automatic answer_type list_apply(logic [2:0] fn, logic [3:0] pos, logic [31:0] v);
      answer_type a;
      int unsigned s, p, n;
      bit pos_ok, full;
      a = '0;
      pos_ok = pos < count;
      full = free_head >= NIL || count >= NIL;
      case (fn)
         FN_GET: begin
            if (!pos_ok) a.status = ST_POS_BAD;
            else a.value_out = vals[slot_of(pos)];
         end
         FN_SET: begin
            if (!pos_ok) a.status = ST_POS_BAD;
            else begin
               s = slot_of(pos);
               a.value_out = vals[s];
               vals[s] = v;
            end
         end
         FN_APPEND, FN_INSERT: begin
            if (fn == FN_INSERT && !pos_ok) a.status = ST_POS_BAD;
            else if (full) a.status = ST_FULL;
            else begin
               n = free_head;
               free_head = links[n];
               vals[n] = v;
               links[n] = NIL;
               if (fn == FN_APPEND) begin
                  if (count == 0) head = n;
                  else links[slot_of(count - 1)] = n;
               end else if (pos == 0) begin
                  links[n] = head;
                  head = n;
               end else begin
                  p = slot_of(pos - 1);
                  links[n] = links[p];
                  links[p] = n;
               end
               count++;
            end
         end
         FN_REMOVE: begin
            if (!pos_ok) a.status = ST_POS_BAD;
            else begin
               if (pos == 0) begin
                  s = head;
                  head = links[s];
               end else begin
                  p = slot_of(pos - 1);
                  s = links[p];
                  links[p] = links[s];
               end
               a.value_out = vals[s];
               links[s] = free_head;
               free_head = s;
               count--;
            end
         end
         FN_SEARCH: begin
            a.status = ST_NOT_FOUND;
            s = head;
            for (int i = 0; i < count; i++) begin
               if (vals[s] == v) begin
                  a.found_pos = 4'(i);
                  a.status = ST_OK;
                  break;
               end
               s = links[s];
            end
         end
         default: ;
      endcase
      a.length = 5'(count);
      return a;
   endfunction

   // send one beat, hold valid across back-to-back beats
   task automatic send_request(logic [2:0] fn, logic [3:0] pos, logic [31:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {4'b0, v, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answers_due.push_back(list_apply(fn, pos, v));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // random position, mostly legal where the list allows it
   function automatic logic [3:0] pick_pos();
      if (count > 0 && $urandom_range(0, 9) < 8) return 4'($urandom_range(0, count - 1));
      return 4'($urandom_range(0, 15));
   endfunction

   // known value or a random one, so searches both hit and miss
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3 && count > 0) return vals[slot_of($urandom_range(0, count - 1))];
      if (r < 5) return $urandom_range(0, 7);
      return $urandom();
   endfunction

   task automatic test_empty_list();
      send_request(FN_GET, 4'd0, 32'd0);
      send_request(FN_SET, 4'd0, 32'hFFFF_FFFF);
      send_request(FN_INSERT, 4'd0, 32'd1);
      send_request(FN_REMOVE, 4'd15, 32'd0);
      send_request(FN_SEARCH, 4'd0, 32'd0);
      send_request(3'd6, 4'd3, 32'd5);
      send_request(3'd7, 4'd15, 32'hFFFF_FFFF);
   endtask

   task automatic test_fill_and_full();
      for (int i = 0; i < SLOTS; i++)
         send_request(FN_APPEND, 4'(i), (i == 0) ? 32'hFFFF_FFFF : 32'(i * 3));
      send_request(FN_APPEND, 4'd0, 32'd9);
      send_request(FN_INSERT, 4'd15, 32'd9);
      send_request(FN_GET, 4'd15, 32'd0);
      send_request(FN_SEARCH, 4'd0, 32'd45);
      send_request(FN_SEARCH, 4'd0, 32'd1);
      send_request(FN_SET, 4'd0, 32'd0);
   endtask

   task automatic test_edit_ops();
      send_request(FN_REMOVE, 4'd0, 32'd0);
      send_request(FN_REMOVE, 4'd14, 32'd0);
      send_request(FN_REMOVE, 4'd5, 32'd0);
      send_request(FN_INSERT, 4'd0, 32'hAAAA_5555);
      send_request(FN_INSERT, 4'd7, 32'h5555_AAAA);
      send_request(FN_GET, 4'd7, 32'd0);
   endtask

   task automatic test_random_ops(int n);
      logic [2:0] fn;
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 20) fn = FN_APPEND;
         else if (r < 35) fn = FN_INSERT;
         else if (r < 55) fn = FN_REMOVE;
         else if (r < 68) fn = FN_GET;
         else if (r < 80) fn = FN_SET;
         else if (r < 97) fn = FN_SEARCH;
         else fn = 3'($urandom_range(6, 7));
         send_request(fn, pick_pos(), pick_value());
         if (k == n / 2) drain();
      end
   endtask

   // result side: random backpressure and in-order check
   initial begin
      int gap;
      forever begin
         gap = pick_gap();
         rsp_tready <= (gap == 0);
         if (gap > 0) begin
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[42:0];
         if (answers_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected beat %h", rsp_tdata);
         end else begin
            want = answers_due.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: want val %h pos %0d st %0d len %0d, got val %h pos %0d st %0d len %0d",
                           want.value_out, want.found_pos, want.status, want.length,
                           got.value_out, got.found_pos, got.status, got.length);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_STOP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      shadow_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_fill_and_full();
      test_edit_ops();
      test_random_ops(2000);
      drain();
      repeat (LATENCY * 2) @(posedge clock);
      if (fail_count == 0 && answers_due.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
